// ----- src/spq_pkg.sv -----
package spq_pkg;

    localparam int PITCH_W  = 19;
    localparam int OFFSET_W = 15;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int DIST_W   = 15;
    localparam int REM_W    = 20;
    localparam int SUM_W    = 21;
    localparam int DIVB_W   = 1;

    localparam int OCTAVE_UNITS = 19200;
    // fourteen octaves of bias keep every pitch non-negative before the split
    localparam int OCTAVE_BIAS  = 14 * OCTAVE_UNITS;
    // quotient step then remainder step
    localparam int DIV_STEPS    = 2;
    // 19200 = 256 * 75; 3496 / 2^18 gives floor(y / 75) exactly for y below 4681
    localparam int OCT_SHIFT    = 8;
    localparam int RECIP        = 3496;
    localparam int RECIP_SHIFT  = 18;
    localparam int PROD_W       = 23;
    localparam int QUO_W        = 5;
    localparam int PITCH_MAX    = 262143;
    localparam int PITCH_MIN    = -262144;

    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_QUANTIZE = 1'b1;

    typedef struct packed {
        logic              clear_wr;
        logic              tone_wr;
        logic              load_pitch;
        logic              div_step;
        logic [DIVB_W-1:0] div_bit;
        logic              rd_en;
        logic              result_load;
    } spq_cmd_t;

    typedef struct packed {
        logic out_blocked;
    } spq_sts_t;

endpackage

// ----- src/spq_ctrl.sv -----
module spq_ctrl #(
    parameter int TONE_SLOTS = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  req_type,
    output logic                                  in_stall,
    input  logic [$clog2(TONE_SLOTS+1)-1:0]       n_lim,
    input  spq_pkg::spq_sts_t                     sts,
    output spq_pkg::spq_cmd_t                     cmd,
    output logic [$clog2(TONE_SLOTS)-1:0]         addr
);
    import spq_pkg::*;

    localparam int AW = $clog2(TONE_SLOTS);
    localparam int NW = $clog2(TONE_SLOTS + 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [DIVB_W-1:0] bit_reg, bit_next;

    assign addr = cnt_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (cnt_reg == NW'(TONE_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (req_type == REQ_QUANTIZE)
                    begin
                        cmd.load_pitch = 1'b1;
                        bit_next       = DIVB_W'(DIV_STEPS - 1);
                        state_next     = ST_DIV;
                    end
                    else
                    begin
                        cmd.tone_wr = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_bit  = bit_reg;
                if (bit_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_SEARCH:
            begin
                // read data is registered ahead of its compare
                if (cnt_reg < n_lim)
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// ----- src/spq_dp.sv -----
module spq_dp #(
    parameter int TONE_SLOTS = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  spq_pkg::spq_cmd_t                     cmd,
    input  logic [$clog2(TONE_SLOTS)-1:0]         addr,
    output logic [$clog2(TONE_SLOTS+1)-1:0]       n_lim,
    output spq_pkg::spq_sts_t                     sts,
    input  logic [spq_pkg::SLOT_W-1:0]            tone_slot,
    input  logic [spq_pkg::OFFSET_W-1:0]          tone_offset,
    input  logic                                  tone_on,
    input  logic signed [spq_pkg::PITCH_W-1:0]    pitch_in,
    input  logic                                  cfg_wr,
    input  logic [spq_pkg::COUNT_W-1:0]           cfg_data,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic signed [spq_pkg::PITCH_W-1:0]    pitch_out,
    output logic [spq_pkg::SLOT_W-1:0]            chosen_slot,
    output logic                                  matched
);
    import spq_pkg::*;

    localparam int AW = $clog2(TONE_SLOTS);
    localparam int NW = $clog2(TONE_SLOTS + 1);
    localparam int MW = OFFSET_W + 1;

    // tone memory: enable bit above the offset
    logic [MW-1:0] mem [TONE_SLOTS];
    logic [MW-1:0] rd_data_reg;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_idx_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic          slot_ok;

    logic [COUNT_W-1:0] count_reg;

    logic signed [PITCH_W-1:0] p_reg;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [PROD_W-1:0]         quo_prod;
    logic [QUO_W-1:0]          quo_reg;
    logic signed [SUM_W-1:0]   p_ext;

    logic                      found_reg, found_next;
    logic [DIST_W-1:0]         best_dist_reg, best_dist_next;
    logic [OFFSET_W-1:0]       best_off_reg, best_off_next;
    logic [AW-1:0]             best_idx_reg, best_idx_next;
    logic signed [OFFSET_W:0]  diff;
    logic [DIST_W-1:0]         cur_dist;
    logic                      take;

    logic signed [SUM_W-1:0]   pos_ext, off_ext, sum;
    logic signed [PITCH_W-1:0] sat;

    logic                      out_valid_reg;
    logic signed [PITCH_W-1:0] pitch_out_reg;
    logic [SLOT_W-1:0]         slot_out_reg;
    logic                      matched_reg;

    assign slot_ok = (32'(tone_slot) < 32'(TONE_SLOTS));
    assign wr_en   = cmd.clear_wr || (cmd.tone_wr && slot_ok);
    assign wr_addr = cmd.clear_wr ? addr : AW'(tone_slot);
    assign wr_data = cmd.clear_wr ? {(addr == '0), OFFSET_W'(0)} : {tone_on, tone_offset};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
        rd_idx_reg <= addr;
    end

    assign n_lim = (32'(count_reg) > 32'(TONE_SLOTS)) ? NW'(TONE_SLOTS) : NW'(count_reg);

    // octave split by reciprocal multiply on the biased pitch
    assign p_ext    = SUM_W'(p_reg);
    assign quo_prod = PROD_W'(rem_reg[REM_W-1:OCT_SHIFT]) * PROD_W'(RECIP);

    always_comb
    begin
        rem_next = rem_reg;
        if (cmd.load_pitch)
        begin
            rem_next = REM_W'(SUM_W'(pitch_in) + SUM_W'(OCTAVE_BIAS));
        end
        else if (cmd.div_step && (cmd.div_bit == '0))
        begin
            rem_next = rem_reg - REM_W'(quo_reg) * REM_W'(OCTAVE_UNITS);
        end
    end

    assign diff = $signed({1'b0, rd_data_reg[OFFSET_W-1:0]})
                - $signed({1'b0, rem_reg[OFFSET_W-1:0]});
    assign cur_dist = diff[OFFSET_W] ? DIST_W'(-diff) : DIST_W'(diff);
    assign take = rd_valid_reg && rd_data_reg[OFFSET_W]
                  && (!found_reg || cur_dist < best_dist_reg);

    always_comb
    begin
        found_next     = found_reg;
        best_dist_next = best_dist_reg;
        best_off_next  = best_off_reg;
        best_idx_next  = best_idx_reg;
        if (cmd.load_pitch)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next     = 1'b1;
            best_dist_next = cur_dist;
            best_off_next  = rd_data_reg[OFFSET_W-1:0];
            best_idx_next  = rd_idx_reg;
        end
    end

    // octave base is pitch minus in-octave position
    assign pos_ext = SUM_W'(rem_reg[OFFSET_W-1:0]);
    assign off_ext = SUM_W'(best_off_reg);
    assign sum     = p_ext - pos_ext + off_ext;

    always_comb
    begin
        if (sum > SUM_W'(PITCH_MAX))
        begin
            sat = PITCH_W'(PITCH_MAX);
        end
        else if (sum < SUM_W'(PITCH_MIN))
        begin
            sat = PITCH_W'(PITCH_MIN);
        end
        else
        begin
            sat = sum[PITCH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pitch)
        begin
            p_reg <= pitch_in;
        end
        if (cmd.div_step && (cmd.div_bit != '0))
        begin
            quo_reg <= quo_prod[PROD_W-1:RECIP_SHIFT];
        end
        rem_reg       <= rem_next;
        best_dist_reg <= best_dist_next;
        best_off_reg  <= best_off_next;
        best_idx_reg  <= best_idx_next;
        if (cmd.result_load)
        begin
            pitch_out_reg <= found_reg ? sat : p_reg;
            slot_out_reg  <= found_reg ? SLOT_W'(best_idx_reg) : '0;
            matched_reg   <= found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_W'(1);
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                count_reg <= cfg_data;
            end
            rd_valid_reg <= cmd.rd_en;
            found_reg    <= found_next;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_blocked = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign pitch_out       = pitch_out_reg;
    assign chosen_slot     = slot_out_reg;
    assign matched         = matched_reg;

endmodule

// ----- src/scale_pitch_quantizer.sv -----
// channel   direction  handshake            payload
// in        input      in_valid / in_stall   req_type tone_slot tone_offset tone_on pitch_in
// out       output     out_valid / out_stall pitch_out chosen_slot matched
// cfg       input      cfg_valid / cfg_ready cfg_data (tone_count)
//
// a tone write leaves the controller idle and ready for another request; a quantize request runs the
// divide steps, then a walk over n tone slots, n being the tone count capped at TONE_SLOTS, then a finish state
// after reset the tone memory is swept over all TONE_SLOTS slots with in_stall high
// the result register lets the next request start while a result waits on out_stall
// cfg_ready is always high
module scale_pitch_quantizer #(
    parameter int TONE_SLOTS = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [0:0]                            req_type,
    input  logic [spq_pkg::SLOT_W-1:0]            tone_slot,
    input  logic [spq_pkg::OFFSET_W-1:0]          tone_offset,
    input  logic [0:0]                            tone_on,
    input  logic signed [spq_pkg::PITCH_W-1:0]    pitch_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [spq_pkg::PITCH_W-1:0]    pitch_out,
    output logic [spq_pkg::SLOT_W-1:0]            chosen_slot,
    output logic [0:0]                            matched,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spq_pkg::COUNT_W-1:0]           cfg_data
);
    import spq_pkg::*;

    localparam int AW = $clog2(TONE_SLOTS);
    localparam int NW = $clog2(TONE_SLOTS + 1);

    spq_cmd_t      cmd;
    spq_sts_t      sts;
    logic [AW-1:0] addr;
    logic [NW-1:0] n_lim;

    assign cfg_ready = 1'b1;

    spq_ctrl #(
        .TONE_SLOTS (TONE_SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type[0]),
        .in_stall (in_stall),
        .n_lim    (n_lim),
        .sts      (sts),
        .cmd      (cmd),
        .addr     (addr)
    );

    spq_dp #(
        .TONE_SLOTS (TONE_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .addr        (addr),
        .n_lim       (n_lim),
        .sts         (sts),
        .tone_slot   (tone_slot),
        .tone_offset (tone_offset),
        .tone_on     (tone_on[0]),
        .pitch_in    (pitch_in),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pitch_out   (pitch_out),
        .chosen_slot (chosen_slot),
        .matched     (matched[0])
    );

endmodule
